// ----- hw/rtl/fourier_expansion_tally_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Fourier expansion tally unit
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FOURIER_EXPANSION_TALLY_UNIT_DEFINES_SVH
`define FOURIER_EXPANSION_TALLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FET_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fet assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fet assertion failed");

`endif

// ----- hw/rtl/fet_pkg.sv -----
// ----------------------------------------------------------------------------
// Fourier expansion tally package
// Types, codes and default sizes shared by the tally unit modules.
// ----------------------------------------------------------------------------
package fet_pkg;

    localparam int FET_AXES             = 3;
    localparam int FET_MAX_ORDER        = 7;
    localparam int FET_COEFF_DEPTH      = 4096;
    localparam int FET_SINE_TABLE_DEPTH = 1024;

    // Axis slots in the register layout, independent of how many are built.
    localparam int NUM_SLOTS = 3;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_FREQ_X   = 3'd3;
    localparam logic [2:0] CFG_FREQ_Y   = 3'd4;
    localparam logic [2:0] CFG_FREQ_Z   = 3'd5;
    localparam logic [2:0] CFG_ORDERS   = 3'd6;

    typedef enum logic [1:0] {
        REQ_SCORE = 2'd0,
        REQ_RECON = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_AXIS,
        ST_F_MUL,
        ST_F_BASE,
        ST_F_PHASE,
        ST_F_ROMA,
        ST_F_ROMB,
        ST_F_COS,
        ST_F_SIN,
        ST_W_START,
        ST_W_AXIS,
        ST_W_MUL,
        ST_W_SHIFT,
        ST_W_OP,
        ST_W_SCORE,
        ST_W_REC1,
        ST_W_REC2,
        ST_W_NEXT,
        ST_R_CHECK,
        ST_R_WAIT,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/fet_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Q1.15 samples of sin over one quarter turn, built at elaboration.
// ----------------------------------------------------------------------------
module fet_sine_rom import fet_pkg::*; #(
    parameter int DEPTH = FET_SINE_TABLE_DEPTH
) (
    input  logic                         aclk,
    input  logic [$clog2(DEPTH):0]       addr,
    output logic [15:0]                  rom_q
);

    localparam int LD = $clog2(DEPTH);

    typedef logic [15:0] tab_t [DEPTH+1];

    // Taylor series to the ninth power on a Q2.30 angle.
    function automatic tab_t build_tab();
        tab_t              tab;
        longint unsigned   a;
        longint unsigned   a2;
        longint unsigned   t;
        longint unsigned   sum;
        longint unsigned   r;
        for (int j = 0; j <= DEPTH; j++) begin
            a   = (HALF_PI_Q30 * longint'(j)) >> LD;
            a2  = (a * a) >> 30;
            t   = a;
            sum = a;
            t   = ((t * a2) >> 30) / 6;
            sum = sum - t;
            t   = ((t * a2) >> 30) / 20;
            sum = sum + t;
            t   = ((t * a2) >> 30) / 42;
            sum = sum - t;
            t   = ((t * a2) >> 30) / 72;
            sum = sum + t;
            r   = (sum + 64'd16384) >> 15;
            tab[j] = (r > 64'd32767) ? 16'd32767 : r[15:0];
        end
        return tab;
    endfunction

    localparam tab_t SINE_TAB = build_tab();

    always_ff @(posedge aclk) begin
        rom_q <= SINE_TAB[addr];
    end

endmodule

// ----- hw/rtl/fet_coeff_mem.sv -----
// ----------------------------------------------------------------------------
// Coefficient store
// Single write port, single registered read port, 48-bit entries.
// ----------------------------------------------------------------------------
module fet_coeff_mem import fet_pkg::*; #(
    parameter int DEPTH = FET_COEFF_DEPTH
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [47:0]                wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [47:0]                rdata
);

    logic signed [47:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/fet_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 multiply with a registered product.
// ----------------------------------------------------------------------------
module fet_mul import fet_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [32:0]   mul_a,
    input  logic signed [32:0]   mul_b,
    output logic signed [65:0]   prod
);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod <= mul_a * mul_b;
        end
    end

endmodule

// ----- hw/rtl/fourier_expansion_tally_unit.sv -----
// ----------------------------------------------------------------------------
// Fourier expansion tally unit
// Tensor-product Fourier coefficient store with score, reconstruct, clear
// and read requests, computed by one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Usage: configuration registers are written through cfg_wr_en, cfg_index
// and cfg_wdata while the unit is idle. Requests arrive as beats on the s_
// channel and each produces exactly one result beat on the m_ channel.
// The unit works on one request at a time; s_ready is high only in idle.
// A score or reconstruct first builds the basis cache: for each active axis
// it multiplies the offset by the frequency, then per harmonic steps the
// phase, reads the table twice and writes cosine and sine. It then walks
// every coefficient of the layout, up to 15x15x15, with one multiply per
// nonzero axis term plus one for score or two for reconstruct; the walk is
// bound by the single multiplier. A clear request sweeps the store, and
// after reset the unit clears the whole store, one entry per cycle, before
// s_ready rises.
// The result sits in an output register: the unit returns to idle and
// takes the next request while an earlier result waits for m_ready; a
// second result waits inside the unit until the first one is taken.
// ----------------------------------------------------------------------------
`include "fourier_expansion_tally_unit_defines.svh"

module fourier_expansion_tally_unit import fet_pkg::*; #(
    parameter int AXES             = FET_AXES,
    parameter int MAX_ORDER        = FET_MAX_ORDER,
    parameter int COEFF_DEPTH      = FET_COEFF_DEPTH,
    parameter int SINE_TABLE_DEPTH = FET_SINE_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic signed [31:0]  s_coord_x,
    input  logic signed [31:0]  s_coord_y,
    input  logic signed [31:0]  s_coord_z,
    input  logic signed [31:0]  s_weight,
    input  logic [11:0]         s_coeff_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_value,
    output logic [1:0]          m_status
);

    localparam int AW          = $clog2(COEFF_DEPTH);
    localparam int LD          = $clog2(SINE_TABLE_DEPTH);
    localparam int TERMS       = 2 * MAX_ORDER + 1;
    localparam int CACHE_DEPTH = AXES * TERMS;
    localparam int CW          = $clog2(CACHE_DEPTH);

    localparam logic signed [47:0] C_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] C_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [63:0] V_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] V_MIN = {1'b1, {63{1'b0}}};

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic signed [31:0] origin_reg [NUM_SLOTS];
    logic [31:0]        freq_reg   [NUM_SLOTS];
    logic [8:0]         orders_reg;

    // Captured request.
    logic [1:0]         req_reg;
    logic signed [31:0] coord_reg [NUM_SLOTS];
    logic signed [31:0] weight_reg;
    logic [11:0]        idx_reg;
    logic [2:0]         n_reg [NUM_SLOTS];

    // Basis fill.
    logic [1:0]         fd_reg;
    logic [2:0]         k_reg;
    logic signed [32:0] u_reg;
    logic [39:0]        base_reg;
    logic [39:0]        phase_reg;
    logic [15:0]        rom_a_reg;
    logic signed [15:0] sin_reg;

    // Coefficient walk.
    logic [AW:0]        f_reg;
    logic [3:0]         mi_reg [NUM_SLOTS];
    logic [3:0]         mi_next [NUM_SLOTS];
    logic [1:0]         ax_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] hiterm_reg;
    logic               sat_reg;

    logic signed [63:0] res_value_reg;
    logic [1:0]         res_status_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               clr_req_reg;

    logic               m_valid_reg;
    logic signed [63:0] m_value_reg;
    logic [1:0]         m_status_reg;

    // Shared units and memories.
    logic               mul_en;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;

    logic [LD:0]        rom_addr;
    logic [15:0]        rom_q;

    logic               cm_we;
    logic [AW-1:0]      cm_waddr;
    logic signed [47:0] cm_wdata;
    logic               cm_re;
    logic [AW-1:0]      cm_raddr;
    logic signed [47:0] cm_q;

    logic               cache_we;
    logic [CW-1:0]      cache_waddr;
    logic signed [15:0] cache_wdata;
    logic               cache_re;
    logic [CW-1:0]      cache_raddr;
    logic signed [15:0] cache_q;
    logic signed [15:0] cache_mem [CACHE_DEPTH];

    logic               accept;
    logic               out_free;
    logic [12:0]        count_w;
    logic [AW:0]        walk_w;
    logic               last_coeff;
    logic               read_bad;
    logic [LD+1:0]      pos_w;
    logic [LD-1:0]      tab_i;
    logic [1:0]         quad_w;
    logic signed [15:0] sv_w;
    logic signed [15:0] cv_w;
    logic [7:0]         fill_term;
    logic [7:0]         walk_term;
    logic [7:0]         u_hi8;
    logic signed [41:0] wb_w;
    logic signed [48:0] csum_w;
    logic signed [47:0] cnew_w;
    logic               csat_w;
    logic signed [63:0] term_w;
    logic signed [64:0] vsum_w;
    logic signed [63:0] vnew_w;
    logic               vsat_w;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // Number of coefficients in the current layout and the walk length.
    assign count_w = 13'({n_reg[0], 1'b1}) * 13'({n_reg[1], 1'b1}) * 13'({n_reg[2], 1'b1});
    assign walk_w  = (count_w > 13'(COEFF_DEPTH)) ? (AW+1)'(COEFF_DEPTH) : (AW+1)'(count_w);
    assign last_coeff = ((f_reg + 1'b1) == walk_w);
    assign read_bad   = ({1'b0, idx_reg} >= count_w) || ({1'b0, idx_reg} >= 13'(COEFF_DEPTH));

    // Phase to table position: top bits of the turn fraction.
    assign pos_w  = phase_reg[39 -: (LD+2)];
    assign tab_i  = pos_w[LD-1:0];
    assign quad_w = pos_w[LD+1:LD];

    always_comb begin
        case (quad_w)
            2'd0: begin
                sv_w = $signed(rom_a_reg);
                cv_w = $signed(rom_q);
            end
            2'd1: begin
                sv_w = $signed(rom_q);
                cv_w = -$signed(rom_a_reg);
            end
            2'd2: begin
                sv_w = -$signed(rom_a_reg);
                cv_w = -$signed(rom_q);
            end
            default: begin
                sv_w = -$signed(rom_q);
                cv_w = $signed(rom_a_reg);
            end
        endcase
    end

    assign fill_term = 8'(fd_reg) * 8'(TERMS) + 8'({k_reg, 1'b0});
    assign walk_term = 8'(ax_reg) * 8'(TERMS) + 8'(mi_reg[ax_reg[1:0] == 2'd3 ? 2'd0 : ax_reg]);
    assign u_hi8     = u_reg[32] ? (8'd0 - freq_reg[fd_reg][7:0]) : 8'd0;

    // Score update with saturation to 48 bits.
    assign wb_w   = prod[63:22];
    assign csum_w = {cm_q[47], cm_q} + {{7{wb_w[41]}}, wb_w};
    assign csat_w = (csum_w[48] != csum_w[47]);
    assign cnew_w = csat_w ? (csum_w[48] ? C_MIN : C_MAX) : csum_w[47:0];

    // Reconstruct accumulation with saturation to 64 bits.
    assign term_w = hiterm_reg + {{20{prod[65]}}, prod[65:22]};
    assign vsum_w = {acc_reg[63], acc_reg} + {term_w[63], term_w};
    assign vsat_w = (vsum_w[64] != vsum_w[63]);
    assign vnew_w = vsat_w ? (vsum_w[64] ? V_MIN : V_MAX) : vsum_w[63:0];

    // Multi-index counter, last axis slot fastest.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int d = NUM_SLOTS - 1; d >= 0; d--) begin
            if (carry && (mi_reg[d] == {n_reg[d], 1'b0})) begin
                mi_next[d] = 4'd0;
            end else begin
                mi_next[d] = mi_reg[d] + 4'(carry);
                carry = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(COEFF_DEPTH - 1)) begin
                    state_next = clr_req_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (req_t'(s_req_type))
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_READ:  state_next = ST_R_CHECK;
                        default:   state_next = ST_F_AXIS;
                    endcase
                end
            end
            ST_F_AXIS: begin
                if (fd_reg == 2'(AXES)) begin
                    state_next = ST_W_START;
                end else if (n_reg[fd_reg] != 3'd0) begin
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL:   state_next = ST_F_BASE;
            ST_F_BASE:  state_next = ST_F_PHASE;
            ST_F_PHASE: state_next = ST_F_ROMA;
            ST_F_ROMA:  state_next = ST_F_ROMB;
            ST_F_ROMB:  state_next = ST_F_COS;
            ST_F_COS:   state_next = ST_F_SIN;
            ST_F_SIN: begin
                state_next = (k_reg == n_reg[fd_reg]) ? ST_F_AXIS : ST_F_PHASE;
            end
            ST_W_START: state_next = ST_W_AXIS;
            ST_W_AXIS: begin
                if (ax_reg == 2'(NUM_SLOTS)) begin
                    state_next = ST_W_OP;
                end else if (mi_reg[ax_reg] != 4'd0) begin
                    state_next = ST_W_MUL;
                end
            end
            ST_W_MUL:   state_next = ST_W_SHIFT;
            ST_W_SHIFT: state_next = ST_W_AXIS;
            ST_W_OP: begin
                state_next = (req_t'(req_reg) == REQ_SCORE) ? ST_W_SCORE : ST_W_REC1;
            end
            ST_W_SCORE: state_next = ST_W_NEXT;
            ST_W_REC1:  state_next = ST_W_REC2;
            ST_W_REC2:  state_next = ST_W_NEXT;
            ST_W_NEXT:  state_next = last_coeff ? ST_DONE : ST_W_START;
            ST_R_CHECK: state_next = read_bad ? ST_DONE : ST_R_WAIT;
            ST_R_WAIT:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control of the shared multiplier, the table and the memories.
    always_comb begin
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        rom_addr    = (LD+1)'(tab_i);
        cm_we       = 1'b0;
        cm_waddr    = f_reg[AW-1:0];
        cm_wdata    = cnew_w;
        cm_re       = 1'b0;
        cm_raddr    = f_reg[AW-1:0];
        cache_we    = 1'b0;
        cache_waddr = CW'(fill_term - 8'd1);
        cache_wdata = cv_w;
        cache_re    = 1'b0;
        cache_raddr = CW'(walk_term);
        case (state_reg)
            ST_CLEAR: begin
                cm_we    = 1'b1;
                cm_waddr = clr_cnt_reg;
                cm_wdata = '0;
            end
            ST_F_MUL: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, u_reg[31:0]};
                mul_b  = {1'b0, freq_reg[fd_reg]};
            end
            ST_F_ROMB: begin
                rom_addr = (LD+1)'(SINE_TABLE_DEPTH) - {1'b0, tab_i};
            end
            ST_F_COS: begin
                cache_we = 1'b1;
            end
            ST_F_SIN: begin
                cache_we    = 1'b1;
                cache_waddr = CW'(fill_term);
                cache_wdata = sin_reg;
            end
            ST_W_START: begin
                cm_re = 1'b1;
            end
            ST_W_AXIS: begin
                cache_re = (ax_reg != 2'(NUM_SLOTS)) && (mi_reg[ax_reg] != 4'd0);
            end
            ST_W_MUL: begin
                mul_en = 1'b1;
                mul_a  = {b_reg[31], b_reg};
                mul_b  = {{17{cache_q[15]}}, cache_q};
            end
            ST_W_OP: begin
                mul_en = 1'b1;
                mul_b  = {b_reg[31], b_reg};
                if (req_t'(req_reg) == REQ_SCORE) begin
                    mul_a = {weight_reg[31], weight_reg};
                end else begin
                    mul_a = {{9{cm_q[47]}}, cm_q[47:24]};
                end
            end
            ST_W_SCORE: begin
                cm_we = 1'b1;
            end
            ST_W_REC1: begin
                mul_en = 1'b1;
                mul_a  = {9'd0, cm_q[23:0]};
                mul_b  = {b_reg[31], b_reg};
            end
            ST_R_CHECK: begin
                cm_re    = !read_bad;
                cm_raddr = AW'(idx_reg);
            end
            default: begin
            end
        endcase
    end

    // Basis cache: values written before they are read within a request.
    always_ff @(posedge aclk) begin
        if (cache_we) begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        if (cache_re) begin
            cache_q <= cache_mem[cache_raddr];
        end
    end

    // Control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_req_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            orders_reg   <= '0;
            for (int d = 0; d < NUM_SLOTS; d++) begin
                origin_reg[d] <= '0;
                freq_reg[d]   <= 32'd16777216;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ORIGIN_X: origin_reg[0] <= $signed(cfg_wdata);
                    CFG_ORIGIN_Y: origin_reg[1] <= $signed(cfg_wdata);
                    CFG_ORIGIN_Z: origin_reg[2] <= $signed(cfg_wdata);
                    CFG_FREQ_X:   freq_reg[0]   <= cfg_wdata;
                    CFG_FREQ_Y:   freq_reg[1]   <= cfg_wdata;
                    CFG_FREQ_Z:   freq_reg[2]   <= cfg_wdata;
                    CFG_ORDERS:   orders_reg    <= cfg_wdata[8:0];
                    default: begin
                    end
                endcase
            end

            // In the done state the output register is loaded below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(COEFF_DEPTH - 1)) begin
                        res_value_reg  <= '0;
                        res_status_reg <= STATUS_OK;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        req_reg      <= s_req_type;
                        coord_reg[0] <= s_coord_x;
                        coord_reg[1] <= s_coord_y;
                        coord_reg[2] <= s_coord_z;
                        weight_reg   <= s_weight;
                        idx_reg      <= s_coeff_index;
                        fd_reg       <= '0;
                        clr_cnt_reg  <= '0;
                        clr_req_reg  <= 1'b1;
                        for (int d = 0; d < NUM_SLOTS; d++) begin
                            if (d >= AXES) begin
                                n_reg[d] <= 3'd0;
                            end else if (orders_reg[3*d +: 3] > 3'(MAX_ORDER)) begin
                                n_reg[d] <= 3'(MAX_ORDER);
                            end else begin
                                n_reg[d] <= orders_reg[3*d +: 3];
                            end
                        end
                    end
                end
                ST_F_AXIS: begin
                    if (fd_reg == 2'(AXES)) begin
                        f_reg   <= '0;
                        acc_reg <= '0;
                        sat_reg <= 1'b0;
                        for (int d = 0; d < NUM_SLOTS; d++) begin
                            mi_reg[d] <= 4'd0;
                        end
                    end else if (n_reg[fd_reg] == 3'd0) begin
                        fd_reg <= fd_reg + 1'b1;
                    end else begin
                        u_reg <= {coord_reg[fd_reg][31], coord_reg[fd_reg]}
                               - {origin_reg[fd_reg][31], origin_reg[fd_reg]};
                    end
                end
                ST_F_BASE: begin
                    // Only the low 40 bits of u*f matter for the turn fraction.
                    base_reg  <= prod[39:0] + {u_hi8, 32'd0};
                    phase_reg <= '0;
                    k_reg     <= 3'd1;
                end
                ST_F_PHASE: begin
                    phase_reg <= phase_reg + base_reg;
                end
                ST_F_ROMB: begin
                    rom_a_reg <= rom_q;
                end
                ST_F_COS: begin
                    sin_reg <= sv_w;
                end
                ST_F_SIN: begin
                    if (k_reg == n_reg[fd_reg]) begin
                        fd_reg <= fd_reg + 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_W_START: begin
                    b_reg  <= 32'sd1073741824;
                    ax_reg <= '0;
                end
                ST_W_AXIS: begin
                    if ((ax_reg != 2'(NUM_SLOTS)) && (mi_reg[ax_reg] == 4'd0)) begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                ST_W_SHIFT: begin
                    b_reg  <= prod[46:15];
                    ax_reg <= ax_reg + 1'b1;
                end
                ST_W_SCORE: begin
                    if (csat_w) begin
                        sat_reg <= 1'b1;
                    end
                end
                ST_W_REC1: begin
                    hiterm_reg <= {prod[61:0], 2'b00};
                end
                ST_W_REC2: begin
                    acc_reg <= vnew_w;
                    if (vsat_w) begin
                        sat_reg <= 1'b1;
                    end
                end
                ST_W_NEXT: begin
                    f_reg <= f_reg + 1'b1;
                    for (int d = 0; d < NUM_SLOTS; d++) begin
                        mi_reg[d] <= mi_next[d];
                    end
                    if (last_coeff) begin
                        res_value_reg  <= (req_t'(req_reg) == REQ_SCORE) ? 64'sd0 : acc_reg;
                        res_status_reg <= sat_reg ? STATUS_SAT : STATUS_OK;
                    end
                end
                ST_R_CHECK: begin
                    if (read_bad) begin
                        res_value_reg  <= '0;
                        res_status_reg <= STATUS_RANGE;
                    end
                end
                ST_R_WAIT: begin
                    res_value_reg  <= {{8{cm_q[47]}}, cm_q, 8'd0};
                    res_status_reg <= STATUS_OK;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    fet_mul u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    fet_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .rom_q (rom_q)
    );

    fet_coeff_mem #(
        .DEPTH (COEFF_DEPTH)
    ) u_coeff_mem (
        .aclk  (aclk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (cm_raddr),
        .rdata (cm_q)
    );

    // A request keeps the unit busy for at least the following cycle.
    `FET_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    // An index error never carries a value.
    `FET_ASSERT_NOW(a_range_zero, aclk, aresetn,
        m_valid && (m_status == STATUS_RANGE), m_value == 64'sd0)
    // The walk never steps past the coefficient count.
    `FET_ASSERT_NOW(a_walk_bound, aclk, aresetn, state_reg == ST_W_NEXT, f_reg < walk_w)

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Fourier expansion tally unit testbench
// Drives score, reconstruct, clear and read beats into the tally unit under
// several register settings. A directed table comes first, then a short
// accumulation sweep, then random phases. Every result beat is checked against
// a fixed-point predictor of the store in this bench, or a typed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fet_pkg::*;

    localparam int  DEPTH    = FET_COEFF_DEPTH;
    localparam int  LUT_SIZE = FET_SINE_TABLE_DEPTH;
    localparam int  TERMS    = 2 * FET_MAX_ORDER + 1;
    localparam longint C_HI  = 64'sd140737488355327;
    localparam longint C_LO  = -64'sd140737488355328;
    localparam longint V_HI  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint V_LO  = 64'sh8000_0000_0000_0000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_req_type;
    logic signed [31:0]  s_coord_x;
    logic signed [31:0]  s_coord_y;
    logic signed [31:0]  s_coord_z;
    logic signed [31:0]  s_weight;
    logic [11:0]         s_coeff_index;
    logic                m_valid;
    logic                m_ready;
    logic signed [63:0]  m_value;
    logic [1:0]          m_status;

    fourier_expansion_tally_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_weight      (s_weight),
        .s_coeff_index (s_coeff_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status)
    );

    // Mirror of the unit's registers and coefficient store.
    logic [31:0] origin_reg [3];
    logic [31:0] freq_reg [3];
    logic [8:0]  orders_reg;
    longint      coeff_mem [DEPTH];
    int          sine_lut [LUT_SIZE + 1];

    // Results still owed by the unit, oldest first.
    longint      pending_value_q [$];
    logic [1:0]  pending_status_q [$];

    int errors;
    int beats_in;
    int beats_out;
    int req_seen [4];
    int sat_seen;
    int range_seen;
    int burst_left;
    bit hold_done;
    bit stim_done;

    typedef struct {
        logic [8:0]  ord;
        req_t        rq;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] w;
        logic [11:0] ix;
        bit          typed;
        longint      ev;
        logic [1:0]  es;
    } stim_row_t;

    stim_row_t directed_q [$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Quarter-wave sine table in Q1.15, built from a truncated Taylor series
    // exactly as the hardware ROM is specified.
    function automatic void build_sine_lut();
        longint unsigned a, a2, t, sum, r;
        for (int j = 0; j <= LUT_SIZE; j++) begin
            a   = (HALF_PI_Q30 * longint'(j)) / LUT_SIZE;
            a2  = (a * a) >> 30;
            t   = a;
            sum = a;
            for (int k = 1; k <= 4; k++) begin
                t = ((t * a2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - t;
                else sum = sum + t;
            end
            r = (sum + 16384) >> 15;
            sine_lut[j] = (r > 32767) ? 32767 : int'(r);
        end
    endfunction

    function automatic int coeff_count();
        int cnt;
        cnt = 1;
        for (int d = 0; d < 3; d++) cnt = cnt * (2 * orders_reg[3 * d +: 3] + 1);
        return cnt;
    endfunction

    // Computes the result of one accepted beat and updates the store mirror.
    function automatic void tally_predict(input req_t rq, input logic [31:0] cx,
                                          input logic [31:0] cy, input logic [31:0] cz,
                                          input logic [31:0] w, input logic [11:0] ix,
                                          output longint val, output logic [1:0] st);
        int unsigned n [3];
        int unsigned len [3];
        int unsigned mi [3];
        int unsigned cnt;
        int bas [3][TERMS];
        logic [31:0] crd [3];
        longint u, bprod, wv, c, hi, lo, term;
        longint unsigned base, ph, pos;
        int q, i, sa, sb, sv, cv;
        crd[0] = cx;
        crd[1] = cy;
        crd[2] = cz;
        val = 0;
        st  = STATUS_OK;
        cnt = 1;
        for (int d = 0; d < 3; d++) begin
            n[d]   = orders_reg[3 * d +: 3];
            len[d] = 2 * n[d] + 1;
            cnt    = cnt * len[d];
            mi[d]  = 0;
        end
        case (rq)
            REQ_CLEAR: begin
                for (int f = 0; f < DEPTH; f++) coeff_mem[f] = 0;
            end
            REQ_READ: begin
                if (ix >= cnt) st = STATUS_RANGE;
                else val = coeff_mem[ix] * 256;
            end
            default: begin
                // Basis values per axis: odd terms cosine, even terms sine.
                for (int d = 0; d < 3; d++) begin
                    u    = longint'($signed(crd[d])) - longint'($signed(origin_reg[d]));
                    base = longint'(u) * longint'({32'd0, freq_reg[d]});
                    for (int k = 1; k <= n[d]; k++) begin
                        ph  = ((base * longint'(k)) >> 8) & 64'hFFFF_FFFF;
                        pos = (ph * (4 * LUT_SIZE)) >> 32;
                        q   = int'(pos / LUT_SIZE) & 3;
                        i   = int'(pos % LUT_SIZE);
                        sa  = sine_lut[i];
                        sb  = sine_lut[LUT_SIZE - i];
                        case (q)
                            0: begin sv = sa;  cv = sb;  end
                            1: begin sv = sb;  cv = -sa; end
                            2: begin sv = -sa; cv = -sb; end
                            default: begin sv = -sb; cv = sa; end
                        endcase
                        bas[d][2 * k - 1] = cv;
                        bas[d][2 * k]     = sv;
                    end
                end
                wv = longint'($signed(w));
                for (int f = 0; f < cnt && f < DEPTH; f++) begin
                    bprod = 64'sd1 << 30;
                    for (int d = 0; d < 3; d++)
                        if (mi[d] != 0) bprod = (bprod * bas[d][mi[d]]) >>> 15;
                    if (rq == REQ_SCORE) begin
                        c = coeff_mem[f] + ((wv * bprod) >>> 22);
                        if (c > C_HI) begin c = C_HI; st = STATUS_SAT; end
                        if (c < C_LO) begin c = C_LO; st = STATUS_SAT; end
                        coeff_mem[f] = c;
                    end else begin
                        c    = coeff_mem[f];
                        hi   = c >>> 24;
                        lo   = c & 64'hFF_FFFF;
                        term = hi * bprod * 4 + ((lo * bprod) >>> 22);
                        if (term > 0 && val > V_HI - term) begin
                            val = V_HI;
                            st  = STATUS_SAT;
                        end else if (term < 0 && val < V_LO - term) begin
                            val = V_LO;
                            st  = STATUS_SAT;
                        end else begin
                            val = val + term;
                        end
                    end
                    // Mixed-radix index step, z fastest.
                    for (int d = 2; d >= 0; d--) begin
                        mi[d]++;
                        if (mi[d] < len[d]) break;
                        mi[d] = 0;
                    end
                end
                if (rq == REQ_SCORE) val = 0;
            end
        endcase
    endfunction

    // Writes all seven registers, one per cycle, and updates the mirror.
    task automatic write_regs(input logic [31:0] org [3], input logic [31:0] frq [3],
                              input logic [8:0] ord);
        for (int r = 0; r < 7; r++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            case (r)
                0: begin cfg_index <= CFG_ORIGIN_X; cfg_wdata <= org[0]; end
                1: begin cfg_index <= CFG_ORIGIN_Y; cfg_wdata <= org[1]; end
                2: begin cfg_index <= CFG_ORIGIN_Z; cfg_wdata <= org[2]; end
                3: begin cfg_index <= CFG_FREQ_X;   cfg_wdata <= frq[0]; end
                4: begin cfg_index <= CFG_FREQ_Y;   cfg_wdata <= frq[1]; end
                5: begin cfg_index <= CFG_FREQ_Z;   cfg_wdata <= frq[2]; end
                default: begin cfg_index <= CFG_ORDERS; cfg_wdata <= {23'd0, ord}; end
            endcase
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        origin_reg = org;
        freq_reg   = frq;
        orders_reg = ord;
    endtask

    // Registers only change once every owed result has come back.
    task automatic wait_drained();
        while (pending_value_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_orders(input logic [8:0] ord);
        wait_drained();
        write_regs(origin_reg, freq_reg, ord);
    endtask

    // Offers one beat. The sender works in bursts; between bursts valid drops
    // for a random gap.
    task automatic send_beat(input req_t rq, input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [31:0] w,
                             input logic [11:0] ix, input bit typed,
                             input longint ev, input logic [1:0] es);
        longint     pv;
        logic [1:0] ps;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(negedge aclk);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_req_type    <= rq;
        s_coord_x     <= cx;
        s_coord_y     <= cy;
        s_coord_z     <= cz;
        s_weight      <= w;
        s_coeff_index <= ix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally_predict(rq, cx, cy, cz, w, ix, pv, ps);
        if (typed) begin
            pv = ev;
            ps = es;
        end
        pending_value_q.push_back(pv);
        pending_status_q.push_back(ps);
        beats_in++;
        req_seen[rq]++;
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
    endtask

    function automatic stim_row_t mk(input logic [8:0] ord, input req_t rq,
                                     input logic [31:0] cx, input logic [31:0] cy,
                                     input logic [31:0] cz, input logic [31:0] w,
                                     input logic [11:0] ix, input bit typed,
                                     input longint ev, input logic [1:0] es);
        stim_row_t r;
        r.ord = ord; r.rq = rq; r.cx = cx; r.cy = cy; r.cz = cz;
        r.w = w; r.ix = ix; r.typed = typed; r.ev = ev; r.es = es;
        return r;
    endfunction

    // Result side: stalls on a pattern of its own, and once holds off for a
    // long stretch so that the unit fills up and drops s_ready.
    initial begin
        int hold_cnt;
        int phase_cnt;
        hold_cnt  = 0;
        phase_cnt = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (!hold_done && beats_in >= 30) begin
                hold_done = 1'b1;
                hold_cnt  = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if ((phase_cnt / 200) % 3 == 2) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Every accepted result beat is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pending_value_q.size() == 0) begin
                $error("result beat with nothing expected: value %0d status %0d",
                       m_value, m_status);
                errors++;
            end else begin
                if (m_value !== pending_value_q[0]) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           pending_value_q[0], m_value);
                    errors++;
                end
                if (m_status !== pending_status_q[0]) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           pending_status_q[0], m_status);
                    errors++;
                end
                void'(pending_value_q.pop_front());
                void'(pending_status_q.pop_front());
            end
            if (m_status == STATUS_SAT) sat_seen++;
            if (m_status == STATUS_RANGE) range_seen++;
        end
    end

    // Hard stop in case the unit hangs.
    initial begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [31:0] org [3];
        logic [31:0] frq [3];
        logic [8:0]  ord;
        logic [31:0] cx, cy, cz, w;
        logic [11:0] ix;
        req_t        rq;
        int          cnt, pick;
        stim_row_t   row;

        errors     = 0;
        beats_in   = 0;
        beats_out  = 0;
        sat_seen   = 0;
        range_seen = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        stim_done  = 1'b0;
        for (int k = 0; k < 4; k++) req_seen[k] = 0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_ORIGIN_X;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_req_type    = REQ_SCORE;
        s_coord_x     = '0;
        s_coord_y     = '0;
        s_coord_z     = '0;
        s_weight      = '0;
        s_coeff_index = '0;

        build_sine_lut();
        for (int d = 0; d < 3; d++) begin
            origin_reg[d] = 32'd0;
            freq_reg[d]   = 32'h0100_0000;
        end
        orders_reg = 9'd0;
        for (int f = 0; f < DEPTH; f++) coeff_mem[f] = 0;

        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The unit sweeps its store after reset before it reports idle.
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        // Directed table. Typed expectations only where they are obvious:
        // the empty store after reset or a clear, out-of-range reads, score and clear.
        directed_q.push_back(mk(9'o000, REQ_READ,  0, 0, 0, 0, 12'd0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_READ,  0, 0, 0, 0, 12'd1, 1, 0, STATUS_RANGE));
        directed_q.push_back(mk(9'o000, REQ_READ,  0, 0, 0, 0, 12'hFFF, 1, 0, STATUS_RANGE));
        directed_q.push_back(mk(9'o000, REQ_SCORE, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                32'h7FFF_FFFF, 0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_READ,  0, 0, 0, 0, 12'd0, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_SCORE, 0, 0, 0, 32'h8000_0000, 0, 1, 0,
                                STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_RECON, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 0, 0, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_CLEAR, 0, 0, 0, 0, 0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o000, REQ_READ,  0, 0, 0, 0, 12'd0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o111, REQ_SCORE, 0, 0, 0, 32'h0001_0000, 0, 1, 0,
                                STATUS_OK));
        directed_q.push_back(mk(9'o111, REQ_SCORE, 32'h0000_4000, 32'hFFFF_C000,
                                32'h0000_8000, 32'h0003_0000, 0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o111, REQ_RECON, 32'h0000_2000, 32'h0001_0000,
                                32'hFFFF_0000, 0, 0, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o111, REQ_READ,  0, 0, 0, 0, 12'd26, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o111, REQ_READ,  0, 0, 0, 0, 12'd27, 1, 0,
                                STATUS_RANGE));
        directed_q.push_back(mk(9'o111, REQ_SCORE, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o007, REQ_SCORE, 32'h0000_3000, 0, 0, 32'h0002_0000,
                                0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o700, REQ_RECON, 0, 0, 32'h0000_5000, 0, 0, 0, 0,
                                STATUS_OK));
        directed_q.push_back(mk(9'o777, REQ_SCORE, 32'h0000_1000, 32'h0000_2000,
                                32'h0000_3000, 32'h7FFF_FFFF, 0, 1, 0, STATUS_OK));
        directed_q.push_back(mk(9'o777, REQ_RECON, 32'h0000_1000, 32'h0000_2000,
                                32'h0000_3000, 0, 0, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o777, REQ_READ,  0, 0, 0, 0, 12'd3374, 0, 0, STATUS_OK));
        directed_q.push_back(mk(9'o777, REQ_READ,  0, 0, 0, 0, 12'd3375, 1, 0,
                                STATUS_RANGE));
        directed_q.push_back(mk(9'o777, REQ_READ,  0, 0, 0, 0, 12'hFFF, 1, 0,
                                STATUS_RANGE));

        foreach (directed_q[k]) begin
            row = directed_q[k];
            if (row.ord != orders_reg) begin
                end_burst();
                set_orders(row.ord);
            end
            send_beat(row.rq, row.cx, row.cy, row.cz, row.w, row.ix, row.typed, row.ev,
                      row.es);
        end

        // Accumulation sweep on a single coefficient: large positive weights,
        // then large negative ones, each followed by a read-back.
        end_burst();
        set_orders(9'o000);
        send_beat(REQ_CLEAR, 0, 0, 0, 0, 0, 1, 0, STATUS_OK);
        for (int k = 0; k < 8; k++)
            send_beat(REQ_SCORE, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, STATUS_OK);
        send_beat(REQ_READ, 0, 0, 0, 0, 12'd0, 0, 0, STATUS_OK);
        for (int k = 0; k < 8; k++)
            send_beat(REQ_SCORE, 0, 0, 0, 32'h8000_0000, 0, 0, 0, STATUS_OK);
        send_beat(REQ_READ, 0, 0, 0, 0, 12'd0, 0, 0, STATUS_OK);
        send_beat(REQ_RECON, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);

        // Random phases. The first two use extreme register values; orders
        // stay small so that each walk is short.
        for (int p = 0; p < 5; p++) begin
            end_burst();
            wait_drained();
            for (int d = 0; d < 3; d++) begin
                case (p)
                    0: begin org[d] = 32'h8000_0000; frq[d] = 32'd0; end
                    1: begin org[d] = 32'h7FFF_FFFF; frq[d] = 32'hFFFF_FFFF; end
                    default: begin
                        org[d] = $urandom();
                        frq[d] = ($urandom_range(0, 1) != 0) ? $urandom()
                                 : $urandom_range(0, 32'h0400_0000);
                    end
                endcase
                ord[3 * d +: 3] = ($urandom_range(0, 7) == 0) ? 3'd3
                                  : 3'($urandom_range(0, 2));
            end
            write_regs(org, frq, ord);
            cnt = coeff_count();
            for (int k = 0; k < 20; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) rq = REQ_SCORE;
                else if (pick < 65) rq = REQ_RECON;
                else if (pick < 92) rq = REQ_READ;
                else rq = REQ_CLEAR;
                if ($urandom_range(0, 1) != 0) begin
                    cx = $urandom();
                    cy = $urandom();
                    cz = $urandom();
                end else begin
                    // Points close to the origin give well-spread phases.
                    cx = origin_reg[0] + $urandom_range(0, 32'h0003_FFFF);
                    cy = origin_reg[1] + $urandom_range(0, 32'h0003_FFFF);
                    cz = origin_reg[2] + $urandom_range(0, 32'h0003_FFFF);
                end
                w  = ($urandom_range(0, 2) != 0) ? $urandom()
                     : 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
                ix = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, cnt - 1))
                     : 12'($urandom_range(0, 4095));
                send_beat(rq, cx, cy, cz, w, ix, 0, 0, STATUS_OK);
            end
        end

        end_burst();
        stim_done = 1'b1;
        // Drain, then a short quiet spell to catch any stray result.
        while (pending_value_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (pending_value_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_value_q.size());
            errors++;
        end

        $display("Covered %0d beats in, %0d out: %0d score, %0d reconstruct, %0d clear,",
                 beats_in, beats_out, req_seen[REQ_SCORE], req_seen[REQ_RECON],
                 req_seen[REQ_CLEAR]);
        $display("%0d read; %0d saturated and %0d out-of-range results, %0d errors.",
                 req_seen[REQ_READ], sat_seen, range_seen, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
